// ===== sv/ift_pkg.sv =====
// types, codes and defaults shared by the interrupt fan-out table
`timescale 1ns / 1ps
`default_nettype none

package ift_pkg;

	localparam int SLOT_W = 6;
	localparam int IRQ_W = 8;
	localparam int CLIENT_SLOTS_DEF = 64;
	localparam int IRQ_COUNT_DEF = 256;

	typedef enum logic [1:0] {
		REQ_OPEN  = 2'd0,
		REQ_SUB   = 2'd1,
		REQ_UNSUB = 2'd2,
		REQ_IRQ   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		KIND_ACK    = 2'd0,
		KIND_OPEN   = 2'd1,
		KIND_TARGET = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RMW,
		ST_LOAD,
		ST_SCAN
	} state_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [SLOT_W-1:0]  client_slot;
		logic [IRQ_W-1:0]   irq_number;
		logic               has_handler;
	} req_t;

	typedef struct packed {
		kind_t              result_kind;
		logic [SLOT_W-1:0]  slot_out;
		logic               success;
		logic [IRQ_W-1:0]   irq_echo;
		logic               last_flag;
	} res_t;

	typedef struct packed {
		logic load;
		logic advance;
	} scan_ctrl_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              last;
		logic              nonempty;
	} scan_stat_t;

endpackage

`default_nettype wire

// ===== sv/ift_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module ift_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/ift_scan.sv =====
// target scanner: walks the set bits of a candidate word, lowest slot first
`timescale 1ns / 1ps
`default_nettype none

module ift_scan #(
	parameter int CLIENT_SLOTS = ift_pkg::CLIENT_SLOTS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ift_pkg::scan_ctrl_t      ctrl,
	input  wire logic [CLIENT_SLOTS-1:0]  load_word,
	output ift_pkg::scan_stat_t           stat
);

	import ift_pkg::*;

	logic [CLIENT_SLOTS-1:0] word_q;
	logic [CLIENT_SLOTS-1:0] rest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (ctrl.load) begin
			word_q <= load_word;
		end else if (ctrl.advance) begin
			word_q <= rest;
		end
	end

	always_comb begin
		stat.slot = '0;
		for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
			if (word_q[i]) begin
				stat.slot = SLOT_W'(i);
			end
		end
		// drop the lowest set bit
		rest = word_q & (word_q - CLIENT_SLOTS'(1));
		stat.last = (rest == '0);
		stat.nonempty = |word_q;
	end

endmodule

`default_nettype wire

// ===== sv/module_interrupt_fanout_table.sv =====
// interrupt fan-out table: client slots, subscription memory and dispatch
//
//   port group        dir   handshake                     payload
//   start/busy        in    taken when start & !busy      request (ift_pkg::req_t)
//   strobe            out   one cycle per result, no hold result  (ift_pkg::res_t)
//
// open, and any subscribe, unsubscribe or dispatch that is rejected up front,
// is answered while idle; subscribe/unsubscribe read the mask row, then write back.
// dispatch reads the mask row, loads the scanner, then gives one target per cycle,
// or a no-target result when nothing matches; every result goes out registered.
// after reset every mask row reads as zero through per-row valid bits, no clear pass.
// the receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps
`default_nettype none

module module_interrupt_fanout_table #(
	parameter int CLIENT_SLOTS = ift_pkg::CLIENT_SLOTS_DEF,
	parameter int IRQ_COUNT    = ift_pkg::IRQ_COUNT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ift_pkg::req_t request,
	output logic               strobe,
	output ift_pkg::res_t      result
);

	import ift_pkg::*;

	localparam int AW   = $clog2(IRQ_COUNT);
	localparam int CNT_W = $clog2(CLIENT_SLOTS + 1);
	localparam int SW1  = SLOT_W + 1;
	localparam int IW1  = IRQ_W + 1;

	state_t state_q, state_d;
	req_t   req_s1;
	logic   vld_s1;
	res_t   res_q, res_d;
	logic   strobe_q, strobe_d;

	logic [CNT_W-1:0]        slot_count_q;
	logic [CLIENT_SLOTS-1:0] handler_q;
	logic [IRQ_COUNT-1:0]    row_vld_q;

	logic                    accept;
	logic                    room;
	logic                    slot_ok;
	logic                    irq_ok;
	logic                    take_open;
	logic                    ram_re;
	logic                    ram_we;
	logic [CLIENT_SLOTS-1:0] ram_rdata;
	logic [CLIENT_SLOTS-1:0] row;
	logic [CLIENT_SLOTS-1:0] slot_bit;
	logic [CLIENT_SLOTS-1:0] row_mod;
	logic [CLIENT_SLOTS-1:0] cand;
	scan_ctrl_t              scan_ctrl;
	scan_stat_t              scan_stat;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign strobe = strobe_q;
	assign result = res_q;

	assign room    = slot_count_q < CNT_W'(CLIENT_SLOTS);
	assign slot_ok = {1'b0, request.client_slot} < SW1'(slot_count_q);
	assign irq_ok  = {1'b0, request.irq_number} < IW1'(IRQ_COUNT);

	// a row never written since reset reads as all clear
	assign row      = vld_s1 ? ram_rdata : '0;
	assign slot_bit = CLIENT_SLOTS'(1) << req_s1.client_slot;
	assign row_mod  = (req_s1.req_type == REQ_SUB) ? (row | slot_bit) : (row & ~slot_bit);
	// handler bits are only ever set for opened slots
	assign cand     = row & handler_q;

	ift_ram #(
		.WIDTH(CLIENT_SLOTS),
		.DEPTH(IRQ_COUNT)
	) u_mask_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req_s1.irq_number[AW-1:0]),
		.wdata (row_mod),
		.re    (ram_re),
		.raddr (request.irq_number[AW-1:0]),
		.rdata (ram_rdata)
	);

	ift_scan #(
		.CLIENT_SLOTS(CLIENT_SLOTS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (scan_ctrl),
		.load_word (cand),
		.stat      (scan_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			req_s1 <= request;
		end
		if (ram_re) begin
			vld_s1 <= row_vld_q[request.irq_number[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= '0;
			handler_q    <= '0;
			row_vld_q    <= '0;
		end else begin
			if (take_open) begin
				slot_count_q <= slot_count_q + CNT_W'(1);
				for (int s = 0; s < CLIENT_SLOTS; s++) begin
					if (CNT_W'(s) == slot_count_q) begin
						handler_q[s] <= request.has_handler;
					end
				end
			end
			if (ram_we) begin
				row_vld_q[req_s1.irq_number[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		res_d     = '0;
		strobe_d  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		take_open = 1'b0;
		scan_ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (request.req_type)
						REQ_OPEN: begin
							strobe_d          = 1'b1;
							res_d.result_kind = KIND_OPEN;
							res_d.last_flag   = 1'b1;
							if (room) begin
								res_d.slot_out = SLOT_W'(slot_count_q);
								res_d.success  = 1'b1;
								take_open      = 1'b1;
							end
						end
						REQ_SUB, REQ_UNSUB: begin
							if (slot_ok && irq_ok) begin
								ram_re  = 1'b1;
								state_d = ST_RMW;
							end else begin
								strobe_d          = 1'b1;
								res_d.result_kind = KIND_ACK;
								res_d.irq_echo    = request.irq_number;
								res_d.last_flag   = 1'b1;
							end
						end
						default: begin
							if (irq_ok) begin
								ram_re  = 1'b1;
								state_d = ST_LOAD;
							end else begin
								strobe_d          = 1'b1;
								res_d.result_kind = KIND_NONE;
								res_d.irq_echo    = request.irq_number;
								res_d.last_flag   = 1'b1;
							end
						end
					endcase
				end
			end
			ST_RMW: begin
				ram_we            = 1'b1;
				strobe_d          = 1'b1;
				res_d.result_kind = KIND_ACK;
				res_d.success     = 1'b1;
				res_d.irq_echo    = req_s1.irq_number;
				res_d.last_flag   = 1'b1;
				state_d           = ST_IDLE;
			end
			ST_LOAD: begin
				if (|cand) begin
					scan_ctrl.load = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					strobe_d          = 1'b1;
					res_d.result_kind = KIND_NONE;
					res_d.irq_echo    = req_s1.irq_number;
					res_d.last_flag   = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_SCAN: begin
				scan_ctrl.advance = 1'b1;
				strobe_d          = 1'b1;
				res_d.result_kind = KIND_TARGET;
				res_d.slot_out    = scan_stat.slot;
				res_d.success     = 1'b1;
				res_d.irq_echo    = req_s1.irq_number;
				res_d.last_flag   = scan_stat.last;
				if (scan_stat.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_stat.nonempty)
		else $error("scanner empty while emitting targets");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_count_q <= CNT_W'(CLIENT_SLOTS))
		else $error("slot count beyond table size");

	a_target_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_flag |=> strobe)
		else $error("dispatch ended without a last target");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> busy)
		else $error("mask read issued but block not busy");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(ram_re))
		else $error("mask write back without a preceding read");

endmodule

`default_nettype wire

// ===== tb/sv/tb_module_interrupt_fanout_table.sv =====
// self-checking testbench for the interrupt fan-out table: directed table, then random traffic
`timescale 1ns / 1ps

module tb_module_interrupt_fanout_table;
	import ift_pkg::*;

	localparam int NSLOTS = CLIENT_SLOTS_DEF;
	localparam int NIRQS = IRQ_COUNT_DEF;
	localparam int RANDOM_ITEMS = 220;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		req_t rq;
		bit   typed;
		res_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic strobe;
	res_t result;

	// shadow of the table
	bit             slot_open [NSLOTS];
	bit             slot_handler [NSLOTS];
	logic [63:0]    irq_mask [NIRQS];
	int             opened;

	res_t           table_answers[$];
	plan_row_t      plan[$];
	logic [7:0]     hot_irq [4];
	int             failures;
	int             cycles;
	bit             quiet;

	module_interrupt_fanout_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.strobe(strobe),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic req_t make_req(req_type_t t, logic [5:0] s, logic [7:0] i, logic h);
		req_t rq;
		rq.req_type = t;
		rq.client_slot = s;
		rq.irq_number = i;
		rq.has_handler = h;
		return rq;
	endfunction

	// answers the table gives for one transaction, updating the shadow state
	function automatic void table_answer(input req_t rq, ref res_t outs[$]);
		res_t r;
		bit found;
		found = 1'b0;
		case (rq.req_type)
			REQ_OPEN: begin
				r = '{KIND_OPEN, 6'd0, 1'b0, 8'd0, 1'b1};
				for (int s = 0; s < NSLOTS; s++) begin
					if (!found && !slot_open[s]) begin
						found = 1'b1;
						slot_open[s] = 1'b1;
						slot_handler[s] = rq.has_handler;
						opened++;
						r.slot_out = 6'(s);
						r.success = 1'b1;
					end
				end
				outs.push_back(r);
			end
			REQ_SUB, REQ_UNSUB: begin
				r = '{KIND_ACK, 6'd0, 1'b0, rq.irq_number, 1'b1};
				if (slot_open[rq.client_slot]) begin
					r.success = 1'b1;
					irq_mask[rq.irq_number][rq.client_slot] = (rq.req_type == REQ_SUB);
				end
				outs.push_back(r);
			end
			default: begin
				for (int s = 0; s < NSLOTS; s++) begin
					if (slot_open[s] && slot_handler[s] && irq_mask[rq.irq_number][s])
						outs.push_back('{KIND_TARGET, 6'(s), 1'b1, rq.irq_number, 1'b0});
				end
				if (outs.size() == 0)
					outs.push_back('{KIND_NONE, 6'd0, 1'b0, rq.irq_number, 1'b1});
				else
					outs[outs.size()-1].last_flag = 1'b1;
			end
		endcase
	endfunction

	// one transaction: idle gap, hold start until taken, then record the answers due
	task automatic submit(req_t rq, bit typed = 1'b0, res_t want = '0);
		res_t outs[$];
		int gap;
		if ($urandom_range(0, 11) == 0)
			quiet = !quiet;
		gap = quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		table_answer(rq, outs);
		if (typed)
			table_answers.push_back(want);
		else
			foreach (outs[k])
				table_answers.push_back(outs[k]);
		@(negedge clk);
	endtask

	task automatic add_row(req_type_t t, logic [5:0] s, logic [7:0] i, logic h,
			bit typed = 1'b0, res_t want = '0);
		plan_row_t row;
		row.rq = make_req(t, s, i, h);
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endtask

	task automatic field_check(string fname, logic [7:0] want_v, logic [7:0] got_v);
		if (got_v !== want_v) begin
			failures++;
			$display("%0t ns: %s expected %0d, got %0d", $time, fname, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && strobe) begin
			if (table_answers.size() == 0) begin
				failures++;
				$display("%0t ns: result expected none, got %p", $time, result);
			end else begin
				want = table_answers.pop_front();
				field_check("result_kind", 8'(want.result_kind), 8'(result.result_kind));
				field_check("slot_out", 8'(want.slot_out), 8'(result.slot_out));
				field_check("success", 8'(want.success), 8'(result.success));
				field_check("irq_echo", want.irq_echo, result.irq_echo);
				field_check("last_flag", 8'(want.last_flag), 8'(result.last_flag));
			end
		end
	end

	function automatic logic [5:0] pick_slot();
		if (opened > 0 && $urandom_range(0, 4) != 0)
			return 6'($urandom_range(0, opened - 1));
		return 6'($urandom_range(0, NSLOTS - 1));
	endfunction

	function automatic logic [7:0] pick_irq();
		if ($urandom_range(0, 99) < 65)
			return hot_irq[$urandom_range(0, 3)];
		return 8'($urandom_range(0, NIRQS - 1));
	endfunction

	function automatic req_t random_request();
		req_t rq;
		int w;
		rq = make_req(REQ_IRQ, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
			$urandom_range(0, 3) != 0);
		w = $urandom_range(0, 99);
		if (w < (opened < NSLOTS ? 35 : 8)) begin
			rq.req_type = REQ_OPEN;
		end else if (w < 65) begin
			rq.req_type = REQ_SUB;
			rq.client_slot = pick_slot();
			rq.irq_number = pick_irq();
		end else if (w < 78) begin
			rq.req_type = REQ_UNSUB;
			rq.client_slot = pick_slot();
			rq.irq_number = pick_irq();
		end else begin
			rq.irq_number = pick_irq();
		end
		return rq;
	endfunction

	initial begin
		int fed;
		int n;
		bit swept;
		logic [7:0] h;

		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		failures = 0;
		cycles = 0;
		opened = 0;
		quiet = 1'b0;
		foreach (slot_open[s]) begin
			slot_open[s] = 1'b0;
			slot_handler[s] = 1'b0;
		end
		foreach (irq_mask[i])
			irq_mask[i] = '0;

		// empty table, absent clients, first opens
		add_row(REQ_IRQ, 6'd0, 8'd0, 1'b0, 1'b1, '{KIND_NONE, 6'd0, 1'b0, 8'd0, 1'b1});
		add_row(REQ_SUB, 6'd0, 8'd0, 1'b1, 1'b1, '{KIND_ACK, 6'd0, 1'b0, 8'd0, 1'b1});
		add_row(REQ_UNSUB, 6'd63, 8'd255, 1'b0, 1'b1, '{KIND_ACK, 6'd0, 1'b0, 8'd255, 1'b1});
		add_row(REQ_OPEN, 6'd63, 8'd255, 1'b1, 1'b1, '{KIND_OPEN, 6'd0, 1'b1, 8'd0, 1'b1});
		add_row(REQ_OPEN, 6'd0, 8'd0, 1'b0, 1'b1, '{KIND_OPEN, 6'd1, 1'b1, 8'd0, 1'b1});
		add_row(REQ_OPEN, 6'd21, 8'd170, 1'b1, 1'b1, '{KIND_OPEN, 6'd2, 1'b1, 8'd0, 1'b1});
		// repeated subscribe and a client with no handler
		add_row(REQ_SUB, 6'd0, 8'd255, 1'b0, 1'b1, '{KIND_ACK, 6'd0, 1'b1, 8'd255, 1'b1});
		add_row(REQ_SUB, 6'd0, 8'd255, 1'b1, 1'b1, '{KIND_ACK, 6'd0, 1'b1, 8'd255, 1'b1});
		add_row(REQ_SUB, 6'd1, 8'd255, 1'b0, 1'b1, '{KIND_ACK, 6'd0, 1'b1, 8'd255, 1'b1});
		add_row(REQ_SUB, 6'd2, 8'd255, 1'b1);
		add_row(REQ_IRQ, 6'd63, 8'd255, 1'b1);
		add_row(REQ_UNSUB, 6'd2, 8'd255, 1'b0);
		add_row(REQ_UNSUB, 6'd2, 8'd255, 1'b1);
		add_row(REQ_IRQ, 6'd42, 8'd255, 1'b0);
		add_row(REQ_IRQ, 6'd0, 8'd128, 1'b0, 1'b1, '{KIND_NONE, 6'd0, 1'b0, 8'd128, 1'b1});
		add_row(REQ_SUB, 6'd1, 8'd128, 1'b0);
		add_row(REQ_IRQ, 6'd0, 8'd128, 1'b1, 1'b1, '{KIND_NONE, 6'd0, 1'b0, 8'd128, 1'b1});
		add_row(REQ_SUB, 6'd63, 8'd7, 1'b1, 1'b1, '{KIND_ACK, 6'd0, 1'b0, 8'd7, 1'b1});
		add_row(REQ_SUB, 6'd2, 8'd0, 1'b0);
		add_row(REQ_SUB, 6'd0, 8'd0, 1'b0);
		add_row(REQ_IRQ, 6'd21, 8'd0, 1'b0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k])
			submit(plan[k].rq, plan[k].typed, plan[k].want);

		hot_irq[0] = 8'd0;
		hot_irq[1] = 8'd255;
		hot_irq[2] = 8'($urandom_range(1, 254));
		hot_irq[3] = 8'($urandom_range(1, 254));
		fed = 0;
		swept = 1'b0;
		while (fed < RANDOM_ITEMS) begin
			if (opened == NSLOTS && !swept) begin
				// full table: every slot on one interrupt, then the widest fan-out
				swept = 1'b1;
				h = hot_irq[$urandom_range(0, 3)];
				for (int s = 0; s < NSLOTS; s++)
					submit(make_req(REQ_SUB, 6'(s), h, 1'($urandom_range(0, 1))));
				submit(make_req(REQ_IRQ, 6'($urandom_range(0, 63)), h,
					1'($urandom_range(0, 1))));
				fed += NSLOTS + 1;
			end else if ($urandom_range(0, 99) < 15) begin
				n = $urandom_range(1, 8);
				h = pick_irq();
				repeat (n)
					submit(make_req(REQ_SUB, pick_slot(), h, 1'($urandom_range(0, 1))));
				submit(make_req(REQ_IRQ, 6'($urandom_range(0, 63)), h,
					1'($urandom_range(0, 1))));
				fed += n + 1;
			end else begin
				submit(random_request());
				fed++;
			end
		end
		start <= 1'b0;

		while (table_answers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
